// ===== hdl/brte_pkg.sv =====
package brte_pkg;

   localparam int BCD_W      = 8;
   localparam int YEAR_W     = 15;   // century*100 + year, at most 16665
   localparam int HMS_W      = 20;   // hour*3600 + minute*60 + second, at most 604065
   localparam int QUOT_W     = 9;    // quotient of the divide-by-25 helper
   localparam int DAYS_W     = 24;   // signed day count
   localparam int PROD_W     = 42;   // signed day count times seconds per day
   localparam int EPOCH_W    = 38;

   localparam logic [YEAR_W-1:0] EPOCH_YEAR         = YEAR_W'(1970);
   localparam logic [DAYS_W-1:0] LEAPS_BEFORE_EPOCH = DAYS_W'(477);
   localparam logic [8:0]        DAYS_PER_YEAR      = 9'd365;
   localparam logic [17:0]       SECS_PER_DAY       = 18'd86400;
   localparam logic [12:0]       RECIP_25           = 13'd5243;  // 2^17 / 25, rounded up

   typedef struct packed {
      logic s3;
      logic s4;
      logic s5;
   } brte_stage_en_type;

   typedef struct packed {
      logic read_failed;
      logic invalid;
   } brte_flag_type;

   // tens*10 + ones, nibbles taken at binary value
   function automatic logic [BCD_W-1:0] bcd_value(input logic [BCD_W-1:0] b);
      return BCD_W'(b[7:4]) * BCD_W'(10) + BCD_W'(b[3:0]);
   endfunction

   // floor(x / 25), exact for x below 4800
   function automatic logic [QUOT_W-1:0] div25(input logic [12:0] x);
      logic [25:0] p;
      p = 26'(x) * 26'(RECIP_25);
      return p[25:17];
   endfunction

   function automatic logic [8:0] days_before_month(input logic [3:0] idx);
      logic [8:0] d;
      unique case (idx)
         4'd0:    d = 9'd0;
         4'd1:    d = 9'd31;
         4'd2:    d = 9'd59;
         4'd3:    d = 9'd90;
         4'd4:    d = 9'd120;
         4'd5:    d = 9'd151;
         4'd6:    d = 9'd181;
         4'd7:    d = 9'd212;
         4'd8:    d = 9'd243;
         4'd9:    d = 9'd273;
         4'd10:   d = 9'd304;
         4'd11:   d = 9'd334;
         default: d = 9'd0;
      endcase
      return d;
   endfunction

endpackage

// ===== hdl/brte_day_count.sv =====
module brte_day_count
   import brte_pkg::*;
(
   input  logic                     clock,
   input  brte_stage_en_type        en,
   input  logic [YEAR_W-1:0]        year,
   input  logic [BCD_W-1:0]         month,
   input  logic [BCD_W-1:0]         day,
   input  logic                     read_failed,
   output logic signed [DAYS_W-1:0] days,
   output brte_flag_type            flags
);

   // stage 3: range check, quotients by 100 and 400
   logic [YEAR_W-1:0] n_in;
   logic [YEAR_W-1:0] s3_year_ff;
   logic [12:0]       s3_x4_ff;
   logic [QUOT_W-1:0] s3_q100_ff, s3_q400_ff, s3_yq100_ff;
   logic [13:0]       s3_yd_ff;
   logic [BCD_W-1:0]  s3_month_ff, s3_day_ff;
   brte_flag_type     s3_flags_ff;

   assign n_in = year - YEAR_W'(1);

   always_ff @(posedge clock) begin
      if (en.s3) begin
         s3_year_ff  <= year;
         s3_x4_ff    <= n_in[14:2];
         s3_q100_ff  <= div25(n_in[14:2]);
         s3_q400_ff  <= div25(13'(n_in[14:4]));
         s3_yq100_ff <= div25(year[14:2]);
         s3_yd_ff    <= 14'(year - EPOCH_YEAR);
         s3_month_ff <= month;
         s3_day_ff   <= day;
         s3_flags_ff.read_failed <= read_failed;
         s3_flags_ff.invalid     <= (year < EPOCH_YEAR) || (month == '0)
                                    || (month > BCD_W'(12));
      end
   end

   // stage 4: leap days so far, leap flag of this year, whole years and months
   logic [YEAR_W-1:0] yrem_in;
   logic              leap_in;
   logic [12:0]       s4_leaps_ff;
   logic [22:0]       s4_yd365_ff;
   logic [8:0]        s4_dbm_ff;
   logic              s4_leap_add_ff;
   logic [BCD_W-1:0]  s4_day_ff;
   brte_flag_type     s4_flags_ff;

   assign yrem_in = s3_year_ff - YEAR_W'(16'(s3_yq100_ff) * 16'd100);
   assign leap_in = (s3_year_ff[1:0] == 2'b00)
                    && ((yrem_in != '0) || (s3_yq100_ff[1:0] == 2'b00));

   always_ff @(posedge clock) begin
      if (en.s4) begin
         s4_leaps_ff    <= s3_x4_ff - 13'(s3_q100_ff) + 13'(s3_q400_ff);
         s4_yd365_ff    <= 23'(s3_yd_ff) * 23'(DAYS_PER_YEAR);
         s4_dbm_ff      <= days_before_month(s3_month_ff[3:0] - 4'd1);
         s4_leap_add_ff <= leap_in && (s3_month_ff > BCD_W'(2));
         s4_day_ff      <= s3_day_ff;
         s4_flags_ff    <= s3_flags_ff;
      end
   end

   // stage 5: day count since the epoch, may be -1 for day 0 of the first month
   logic [DAYS_W-1:0]        sum_in;
   logic signed [DAYS_W-1:0] s5_days_ff;
   brte_flag_type            s5_flags_ff;

   assign sum_in = DAYS_W'(s4_yd365_ff) + DAYS_W'(s4_leaps_ff) + DAYS_W'(s4_dbm_ff)
                 + DAYS_W'(s4_leap_add_ff) + DAYS_W'(s4_day_ff)
                 - LEAPS_BEFORE_EPOCH - DAYS_W'(1);

   always_ff @(posedge clock) begin
      if (en.s5) begin
         s5_days_ff  <= $signed(sum_in);
         s5_flags_ff <= s4_flags_ff;
      end
   end

   assign days  = s5_days_ff;
   assign flags = s5_flags_ff;

endmodule

// ===== hdl/bcd_rtc_to_epoch_seconds_top.sv =====
// Converts one real-time-clock reading (packed BCD century, year, month, day, hour,
// minute, second plus a read-failure flag) into seconds since 1970-01-01 00:00:00,
// Gregorian leap rule. Seven-stage pipeline: a request is taken every cycle unless
// req_stall is high, and its response comes from the stage 7 register; rate is one
// request per clock while rsp_stall stays low, set by the pipeline, with each stage
// holding only while it is full and the stage after it is holding too.
// A failed read gives 1 with date_valid low; a year before 1970 or a month outside
// 1..12 gives 0 with date_valid low. Results below zero clamp to 0 and results past
// 38 bits clamp to all ones, date_valid staying high. No reset-time sweep is needed.
module bcd_rtc_to_epoch_seconds_top
   import brte_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_read_failed,
   input  logic [BCD_W-1:0]    req_century_bcd,
   input  logic [BCD_W-1:0]    req_year_bcd,
   input  logic [BCD_W-1:0]    req_month_bcd,
   input  logic [BCD_W-1:0]    req_day_bcd,
   input  logic [BCD_W-1:0]    req_hour_bcd,
   input  logic [BCD_W-1:0]    req_minute_bcd,
   input  logic [BCD_W-1:0]    req_second_bcd,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [EPOCH_W-1:0]  rsp_epoch_seconds,
   output logic                rsp_date_valid
);

   localparam int STAGES = 7;

   // ---- stage control: a stage loads when empty or when the next one loads ----
   logic [STAGES:1] valid_ff;
   logic [STAGES:1] en;

   always_comb begin
      en[STAGES] = !valid_ff[STAGES] || !rsp_stall;
      for (int k = STAGES - 1; k >= 1; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (en[1]) begin
            valid_ff[1] <= req_valid;
         end
         for (int k = 2; k <= STAGES; k++) begin
            if (en[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   assign req_stall = !en[1];
   assign rsp_valid = valid_ff[STAGES];

   // ---- stage 1: BCD bytes to binary ----
   logic             s1_rf_ff;
   logic [BCD_W-1:0] s1_cent_ff, s1_year_ff, s1_month_ff, s1_day_ff;
   logic [BCD_W-1:0] s1_hour_ff, s1_min_ff, s1_sec_ff;

   always_ff @(posedge clock) begin
      if (en[1]) begin
         s1_rf_ff    <= req_read_failed;
         s1_cent_ff  <= bcd_value(req_century_bcd);
         s1_year_ff  <= bcd_value(req_year_bcd);
         s1_month_ff <= bcd_value(req_month_bcd);
         s1_day_ff   <= bcd_value(req_day_bcd);
         s1_hour_ff  <= bcd_value(req_hour_bcd);
         s1_min_ff   <= bcd_value(req_minute_bcd);
         s1_sec_ff   <= bcd_value(req_second_bcd);
      end
   end

   // ---- stage 2: full year, seconds within the day ----
   logic              s2_rf_ff;
   logic [YEAR_W-1:0] s2_year_ff;
   logic [BCD_W-1:0]  s2_month_ff, s2_day_ff;
   logic [HMS_W-1:0]  s2_hms_ff;

   always_ff @(posedge clock) begin
      if (en[2]) begin
         s2_rf_ff    <= s1_rf_ff;
         s2_year_ff  <= YEAR_W'(s1_cent_ff) * YEAR_W'(100) + YEAR_W'(s1_year_ff);
         s2_month_ff <= s1_month_ff;
         s2_day_ff   <= s1_day_ff;
         s2_hms_ff   <= HMS_W'(s1_hour_ff) * HMS_W'(3600) + HMS_W'(s1_min_ff) * HMS_W'(60)
                      + HMS_W'(s1_sec_ff);
      end
   end

   // ---- stages 3 to 5: day count ----
   brte_stage_en_type        day_en;
   logic signed [DAYS_W-1:0] dc_days;
   brte_flag_type            dc_flags;

   assign day_en.s3 = en[3];
   assign day_en.s4 = en[4];
   assign day_en.s5 = en[5];

   brte_day_count u_day_count (
      .clock       (clock),
      .en          (day_en),
      .year        (s2_year_ff),
      .month       (s2_month_ff),
      .day         (s2_day_ff),
      .read_failed (s2_rf_ff),
      .days        (dc_days),
      .flags       (dc_flags)
   );

   // seconds within the day ride alongside the day count
   logic [HMS_W-1:0] s3_hms_ff, s4_hms_ff, s5_hms_ff;

   always_ff @(posedge clock) begin
      if (en[3]) s3_hms_ff <= s2_hms_ff;
      if (en[4]) s4_hms_ff <= s3_hms_ff;
      if (en[5]) s5_hms_ff <= s4_hms_ff;
   end

   // ---- stage 6: days to seconds ----
   logic signed [PROD_W-1:0] s6_prod_ff;
   logic [HMS_W-1:0]         s6_hms_ff;
   brte_flag_type            s6_flags_ff;

   always_ff @(posedge clock) begin
      if (en[6]) begin
         s6_prod_ff  <= PROD_W'(dc_days) * $signed(PROD_W'(SECS_PER_DAY));
         s6_hms_ff   <= s5_hms_ff;
         s6_flags_ff <= dc_flags;
      end
   end

   // ---- stage 7: final add, clamp, special cases ----
   logic signed [PROD_W-1:0] total_in;
   logic [EPOCH_W-1:0]       secs_in;
   logic                     dvalid_in;
   logic [EPOCH_W-1:0]       s7_secs_ff;
   logic                     s7_dvalid_ff;

   assign total_in = s6_prod_ff + $signed({{(PROD_W-HMS_W){1'b0}}, s6_hms_ff});

   always_comb begin
      priority if (s6_flags_ff.read_failed) begin
         secs_in   = EPOCH_W'(1);
         dvalid_in = 1'b0;
      end else if (s6_flags_ff.invalid) begin
         secs_in   = '0;
         dvalid_in = 1'b0;
      end else if (total_in[PROD_W-1]) begin
         secs_in   = '0;
         dvalid_in = 1'b1;
      end else if (|total_in[PROD_W-2:EPOCH_W]) begin
         secs_in   = '1;
         dvalid_in = 1'b1;
      end else begin
         secs_in   = total_in[EPOCH_W-1:0];
         dvalid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (en[7]) begin
         s7_secs_ff   <= secs_in;
         s7_dvalid_ff <= dvalid_in;
      end
   end

   assign rsp_epoch_seconds = s7_secs_ff;
   assign rsp_date_valid    = s7_dvalid_ff;

endmodule

// ===== bench/bcd_rtc_to_epoch_seconds_top_test.sv =====
`timescale 1ns / 1ps

module bcd_rtc_to_epoch_seconds_top_test
   import brte_pkg::*;
;

   // Behavioural constants
   localparam longint BASE_YEAR     = 1970;
   localparam longint DAY_SECS      = 86400;
   localparam longint YEAR_DAYS     = 365;
   localparam longint EPOCH_CEILING = (longint'(1) << EPOCH_W) - 1;

   // Traffic shaping
   localparam int IDLE_PCT     = 23;     // chance of a gap / stall per cycle
   localparam int QUIET_FIRST  = 700;    // window with no gaps and no stalls
   localparam int QUIET_LAST   = 1099;
   localparam int DIRECTED_CNT = 25;
   localparam int RANDOM_CNT   = 1925;
   localparam int DRAIN_AT_A   = DIRECTED_CNT;  // pipeline emptied after these
   localparam int DRAIN_AT_B   = 1300;
   localparam int SETTLE_CYCLES = 20;

   typedef struct {
      logic             read_failed;
      logic [BCD_W-1:0] century;
      logic [BCD_W-1:0] year;
      logic [BCD_W-1:0] month;
      logic [BCD_W-1:0] day;
      logic [BCD_W-1:0] hour;
      logic [BCD_W-1:0] minute;
      logic [BCD_W-1:0] second;
   } rtc_reading_type;

   typedef struct {
      logic [EPOCH_W-1:0] seconds;
      logic               date_valid;
   } epoch_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_read_failed = 1'b0;
   logic [BCD_W-1:0]   req_century_bcd = '0;
   logic [BCD_W-1:0]   req_year_bcd = '0;
   logic [BCD_W-1:0]   req_month_bcd = '0;
   logic [BCD_W-1:0]   req_day_bcd = '0;
   logic [BCD_W-1:0]   req_hour_bcd = '0;
   logic [BCD_W-1:0]   req_minute_bcd = '0;
   logic [BCD_W-1:0]   req_second_bcd = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [EPOCH_W-1:0] rsp_epoch_seconds;
   logic               rsp_date_valid;

   rtc_reading_type  readings_to_send[$];
   epoch_result_type expected_times[$];

   // Handshake counters, updated with NBAs so both always blocks see
   // pre-edge values whatever order they run in
   int unsigned accepted_count = 0;
   int unsigned received_count = 0;
   int unsigned issued = 0;
   int unsigned mismatch_count = 0;
   logic        draining = 1'b0;

   bcd_rtc_to_epoch_seconds_top DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_read_failed   (req_read_failed),
      .req_century_bcd   (req_century_bcd),
      .req_year_bcd      (req_year_bcd),
      .req_month_bcd     (req_month_bcd),
      .req_day_bcd       (req_day_bcd),
      .req_hour_bcd      (req_hour_bcd),
      .req_minute_bcd    (req_minute_bcd),
      .req_second_bcd    (req_second_bcd),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_epoch_seconds (rsp_epoch_seconds),
      .rsp_date_valid    (rsp_date_valid)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Behavioural calculation
   // ---------------------------------------------------------------------

   // Nibbles 10..15 keep their binary weight, so 0xFF reads as 165
   function automatic longint bcd_to_bin(input logic [BCD_W-1:0] b);
      return longint'(b[7:4]) * 10 + longint'(b[3:0]);
   endfunction

   function automatic logic [BCD_W-1:0] to_bcd(input int v);
      return {4'(v / 10), 4'(v % 10)};
   endfunction

   function automatic bit is_leap_year(input longint y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
   endfunction

   // number of leap years in 1..n
   function automatic longint leaps_upto(input longint n);
      return n / 4 - n / 100 + n / 400;
   endfunction

   // days in the months before mo, common year
   function automatic longint cumulative_days(input longint mo);
      case (mo)
         1:       return 0;
         2:       return 31;
         3:       return 59;
         4:       return 90;
         5:       return 120;
         6:       return 151;
         7:       return 181;
         8:       return 212;
         9:       return 243;
         10:      return 273;
         11:      return 304;
         default: return 334;
      endcase
   endfunction

   function automatic epoch_result_type rtc_reading_to_epoch(input rtc_reading_type r);
      epoch_result_type res;
      longint yr, mo, days, secs;
      res.seconds    = '0;
      res.date_valid = 1'b0;
      if (r.read_failed) begin
         res.seconds = EPOCH_W'(1);
         return res;
      end
      yr = bcd_to_bin(r.century) * 100 + bcd_to_bin(r.year);
      mo = bcd_to_bin(r.month);
      if (yr < BASE_YEAR || mo < 1 || mo > 12)
         return res;
      // leap day of this year only counts once February is over
      days = (yr - BASE_YEAR) * YEAR_DAYS
           + leaps_upto(yr - 1) - leaps_upto(BASE_YEAR - 1)
           + cumulative_days(mo)
           + ((is_leap_year(yr) && mo > 2) ? 1 : 0)
           + bcd_to_bin(r.day) - 1;
      secs = days * DAY_SECS + bcd_to_bin(r.hour) * 3600
           + bcd_to_bin(r.minute) * 60 + bcd_to_bin(r.second);
      // clamp at both ends, date stays flagged valid
      if (secs < 0)
         secs = 0;
      if (secs > EPOCH_CEILING)
         secs = EPOCH_CEILING;
      res.seconds    = EPOCH_W'(secs);
      res.date_valid = 1'b1;
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus generation
   // ---------------------------------------------------------------------

   task automatic add_reading(input logic rf, input logic [7:0] c, y, mo, d, h, mi, s);
      rtc_reading_type r;
      r.read_failed = rf;
      r.century     = c;
      r.year        = y;
      r.month       = mo;
      r.day         = d;
      r.hour        = h;
      r.minute      = mi;
      r.second      = s;
      readings_to_send.push_back(r);
   endtask

   function automatic int month_length(input int yr, input int mo);
      case (mo)
         2:            return is_leap_year(yr) ? 29 : 28;
         4, 6, 9, 11:  return 30;
         default:      return 31;
      endcase
   endfunction

   // Mostly proper calendar dates; the rest is sloppy fields, raw noise and
   // failed reads
   function automatic rtc_reading_type random_reading();
      rtc_reading_type r;
      int pick, yr, mo, span;
      pick = $urandom_range(99);
      span = $urandom_range(9);
      if (span < 8)
         yr = $urandom_range(2199, 1970);
      else if (span == 8)
         yr = $urandom_range(1969, 1900);
      else
         yr = $urandom_range(9999, 2200);
      mo = $urandom_range(12, 1);
      r.read_failed = 1'b0;
      r.century     = to_bcd(yr / 100);
      r.year        = to_bcd(yr % 100);
      r.month       = to_bcd(mo);
      r.day         = to_bcd($urandom_range(month_length(yr, mo), 1));
      r.hour        = to_bcd($urandom_range(23));
      r.minute      = to_bcd($urandom_range(59));
      r.second      = to_bcd($urandom_range(59));
      if (pick < 70) begin
         // well-formed date, nothing more to do
      end else if (pick < 80) begin
         // decimal digits but out-of-range day / time, month 0..13
         r.month  = to_bcd($urandom_range(13));
         r.day    = to_bcd($urandom_range(99));
         r.hour   = to_bcd($urandom_range(99));
         r.minute = to_bcd($urandom_range(99));
         r.second = to_bcd($urandom_range(99));
      end else begin
         r.century = 8'($urandom);
         r.year    = 8'($urandom);
         r.month   = 8'($urandom);
         r.day     = 8'($urandom);
         r.hour    = 8'($urandom);
         r.minute  = 8'($urandom);
         r.second  = 8'($urandom);
         r.read_failed = (pick >= 95);
      end
      return r;
   endfunction

   task automatic note_mismatch(input string what);
      $display("%0t ns  ERROR: %s", $time, what);
      mismatch_count++;
   endtask

   // ---------------------------------------------------------------------
   // Driver: one request on the bus at a time, held while stalled
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      rtc_reading_type nxt;
      bit quiet;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            accepted_count <= accepted_count + 1;
         // drain pause over once the bus is empty and everything has come back
         if (draining && !req_valid && accepted_count == received_count)
            draining = 1'b0;
         if (!req_valid || !req_stall) begin
            quiet = (issued >= QUIET_FIRST && issued <= QUIET_LAST);
            if (readings_to_send.size() != 0 && !draining &&
                (quiet || $urandom_range(99) >= IDLE_PCT)) begin
               nxt = readings_to_send.pop_front();
               req_read_failed <= nxt.read_failed;
               req_century_bcd <= nxt.century;
               req_year_bcd    <= nxt.year;
               req_month_bcd   <= nxt.month;
               req_day_bcd     <= nxt.day;
               req_hour_bcd    <= nxt.hour;
               req_minute_bcd  <= nxt.minute;
               req_second_bcd  <= nxt.second;
               req_valid       <= 1'b1;
               // predicted at presentation: order on the bus is acceptance order
               expected_times.push_back(rtc_reading_to_epoch(nxt));
               issued++;
               if (issued == DRAIN_AT_A || issued == DRAIN_AT_B)
                  draining = 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: random back-pressure and field-by-field comparison
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      epoch_result_type want;
      bit quiet;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            received_count <= received_count + 1;
            if (expected_times.size() == 0) begin
               note_mismatch($sformatf("response with nothing outstanding: %0d / %b",
                                       rsp_epoch_seconds, rsp_date_valid));
            end else begin
               want = expected_times.pop_front();
               if (rsp_epoch_seconds !== want.seconds)
                  note_mismatch($sformatf("response %0d epoch_seconds %0d, wanted %0d",
                                          received_count, rsp_epoch_seconds,
                                          want.seconds));
               if (rsp_date_valid !== want.date_valid)
                  note_mismatch($sformatf("response %0d date_valid %b, wanted %b",
                                          received_count, rsp_date_valid,
                                          want.date_valid));
            end
         end
         quiet = (received_count >= QUIET_FIRST && received_count <= QUIET_LAST);
         rsp_stall <= quiet ? 1'b0 : ($urandom_range(99) < IDLE_PCT);
      end
   end

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin
      // failed reads: everything else is ignored
      add_reading(1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      add_reading(1'b1, 8'h20, 8'h24, 8'h06, 8'h15, 8'h12, 8'h30, 8'h45);
      // the epoch itself and one second after
      add_reading(1'b0, 8'h19, 8'h70, 8'h01, 8'h01, 8'h00, 8'h00, 8'h00);
      add_reading(1'b0, 8'h19, 8'h70, 8'h01, 8'h01, 8'h00, 8'h00, 8'h01);
      // day 0 of the epoch: negative sum clamps to zero, still valid
      add_reading(1'b0, 8'h19, 8'h70, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00);
      add_reading(1'b0, 8'h19, 8'h70, 8'h01, 8'h00, 8'h23, 8'h59, 8'h59);
      // year before the epoch, month 0 and 13
      add_reading(1'b0, 8'h19, 8'h69, 8'h12, 8'h31, 8'h23, 8'h59, 8'h59);
      add_reading(1'b0, 8'h20, 8'h24, 8'h00, 8'h10, 8'h00, 8'h00, 8'h00);
      add_reading(1'b0, 8'h20, 8'h24, 8'h13, 8'h10, 8'h00, 8'h00, 8'h00);
      add_reading(1'b0, 8'h00, 8'h00, 8'h01, 8'h01, 8'h00, 8'h00, 8'h00);
      add_reading(1'b0, 8'h00, 8'hFF, 8'h06, 8'h01, 8'h00, 8'h00, 8'h00);
      // leap handling: leap day, after it, 400 and 100 rules
      add_reading(1'b0, 8'h20, 8'h24, 8'h02, 8'h29, 8'h12, 8'h00, 8'h00);
      add_reading(1'b0, 8'h20, 8'h24, 8'h03, 8'h01, 8'h00, 8'h00, 8'h00);
      add_reading(1'b0, 8'h20, 8'h24, 8'h12, 8'h31, 8'h23, 8'h59, 8'h59);
      add_reading(1'b0, 8'h20, 8'h00, 8'h03, 8'h01, 8'h00, 8'h00, 8'h00);
      add_reading(1'b0, 8'h21, 8'h00, 8'h03, 8'h01, 8'h00, 8'h00, 8'h00);
      add_reading(1'b0, 8'h20, 8'h38, 8'h01, 8'h19, 8'h03, 8'h14, 8'h08);
      // non-decimal nibbles taken at binary weight
      add_reading(1'b0, 8'h20, 8'h23, 8'h0C, 8'h05, 8'h00, 8'h00, 8'h00);
      add_reading(1'b0, 8'h20, 8'h23, 8'h0A, 8'h0F, 8'h1A, 8'h5F, 8'h6E);
      add_reading(1'b0, 8'h19, 8'h70, 8'h1F, 8'h01, 8'h00, 8'h00, 8'h00);
      add_reading(1'b0, 8'hA0, 8'h00, 8'h01, 8'h01, 8'h00, 8'h00, 8'h00);
      // unchecked day / time fields
      add_reading(1'b0, 8'h20, 8'h24, 8'h01, 8'h99, 8'h99, 8'h99, 8'h99);
      // largest decimal date, then a sum past 38 bits that must saturate
      add_reading(1'b0, 8'h99, 8'h99, 8'h12, 8'h31, 8'h23, 8'h59, 8'h59);
      add_reading(1'b0, 8'hFF, 8'hFF, 8'h12, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      add_reading(1'b0, 8'h19, 8'h99, 8'h12, 8'h31, 8'h23, 8'h59, 8'h59);

      repeat (RANDOM_CNT)
         readings_to_send.push_back(random_reading());

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // wait for the queue to empty and every accepted request to be answered
      while (readings_to_send.size() != 0 || req_valid ||
             expected_times.size() != 0 || received_count != accepted_count)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (expected_times.size() != 0)
         note_mismatch($sformatf("%0d responses never arrived", expected_times.size()));

      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Watchdog, far beyond a fully stalled run
   initial begin
      #5_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ===== files.f =====
hdl/brte_pkg.sv
hdl/brte_day_count.sv
hdl/bcd_rtc_to_epoch_seconds_top.sv
bench/bcd_rtc_to_epoch_seconds_top_test.sv
